/* hdl/srctl_pkg.sv */
// ----------------------------------------------------------------------------
// srctl_pkg: shared types and constants for the stream rate controller
// Field widths, register indexes, reset values, the sequencer's state
// encoding and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package srctl_pkg;

  // Field widths
  localparam int OCC_W      = 24;
  localparam int GAMMA_W    = 16;
  localparam int RATE_W     = 32;
  localparam int STEP_W     = 31;
  localparam int FACTOR_W   = 25;
  localparam int GAIN_W     = 24;
  localparam int PAYLOAD_W  = 16;
  localparam int MODE_W     = 2;
  localparam int ERR_W      = OCC_W + 1;
  localparam int GP_W       = GAMMA_W + PAYLOAD_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Shared multiplier: signed A by unsigned B
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 25;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W + 1;
  localparam int DLOW_W     = MUL_A_W - 1;

  // Register reset values
  localparam logic [STEP_W-1:0]          STEP_RST    = STEP_W'(65536);
  localparam logic [FACTOR_W-1:0]        FACTOR_RST  = FACTOR_W'(8388608);
  localparam logic [GAIN_W-1:0]          GAIN_RST    = '0;
  localparam logic [PAYLOAD_W-1:0]       PAYLOAD_RST = PAYLOAD_W'(1024);
  localparam logic signed [RATE_W-1:0]   RATE_RST    = RATE_W'(65536);

  // Rate range ends
  localparam logic signed [RATE_W-1:0]   RATE_MAX    = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0]   RATE_MIN    = {1'b1, {(RATE_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_MULT  = 2'd1,
    MODE_PROP  = 2'd2,
    MODE_DRAIN = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_STEP    = 3'd1,
    REG_FACTOR  = 3'd2,
    REG_EGAIN   = 3'd3,
    REG_DGAIN   = 3'd4,
    REG_PAYLOAD = 3'd5,
    REG_INIT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    mode_t                  mode;
    logic [STEP_W-1:0]      rate_step;
    logic [FACTOR_W-1:0]    decrease_factor;
    logic [GAIN_W-1:0]      error_gain;
    logic [GAIN_W-1:0]      drain_gain;
    logic [PAYLOAD_W-1:0]   payload_bytes;
  } srctl_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCALE,
    S_TERM,
    S_DRAIN,
    S_MUL_DL,
    S_MUL_DH,
    S_DACC,
    S_SUB,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_RATE,
    MUL_ERR,
    MUL_PAY,
    MUL_DLOW,
    MUL_DHIGH
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ADD_STEP,
    ACC_SUB_STEP,
    ACC_SCALE,
    ACC_ADD_TERM,
    ACC_SUB_DRAIN
  } acc_op_t;

  typedef enum logic [1:0] {
    DACC_HOLD,
    DACC_LOAD,
    DACC_ADD_HIGH
  } dacc_op_t;

  typedef struct packed {
    logic      load;
    mul_sel_t  mul_sel;
    acc_op_t   acc_op;
    logic      drain_load;
    dacc_op_t  dacc_op;
    logic      commit;
  } srctl_cmd_t;

  typedef struct packed {
    logic err_pos;
    logic err_neg;
  } srctl_status_t;

endpackage

`default_nettype wire

/* hdl/srctl_feed_if.sv */
// ----------------------------------------------------------------------------
// srctl_feed_if: receiver feedback channel
// Valid/ready channel carrying one feedback item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface srctl_feed_if;
  logic                             valid;
  logic                             ready;
  logic [srctl_pkg::OCC_W-1:0]      occupancy;
  logic [srctl_pkg::OCC_W-1:0]      target_level;
  logic [srctl_pkg::GAMMA_W-1:0]    playback_rate;

  modport source (output valid, output occupancy, output target_level,
                  output playback_rate, input ready);
  modport sink   (input valid, input occupancy, input target_level,
                  input playback_rate, output ready);
endinterface

`default_nettype wire

/* hdl/srctl_rate_if.sv */
// ----------------------------------------------------------------------------
// srctl_rate_if: updated rate channel
// Valid/ready channel carrying one rate result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface srctl_rate_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [srctl_pkg::RATE_W-1:0]    new_rate;
  logic                                   below_one;
  logic                                   saturated;

  modport source (output valid, output new_rate, output below_one,
                  output saturated, input ready);
  modport sink   (input valid, input new_rate, input below_one,
                  input saturated, output ready);
endinterface

`default_nettype wire

/* hdl/srctl_cfg_if.sv */
// ----------------------------------------------------------------------------
// srctl_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface srctl_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [srctl_pkg::CFG_IDX_W-1:0]      index;
  logic [srctl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/srctl_regs.sv */
// ----------------------------------------------------------------------------
// srctl_regs: configuration register bank
// Decodes write beats into the control registers; a write to the initial
// rate register raises a one-cycle load towards the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module srctl_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  srctl_cfg_if.sink                              cfg,
  output srctl_pkg::srctl_cfg_t                  regs,
  output logic                                   rate_load,
  output logic signed [srctl_pkg::RATE_W-1:0]    rate_init
);

  logic wr;

  // Writes are always taken
  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  // Initial rate goes straight into the kept rate
  assign rate_load = wr && (cfg.index == srctl_pkg::REG_INIT);
  assign rate_init = cfg.data[srctl_pkg::RATE_W-1:0];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode            <= srctl_pkg::MODE_ADD;
      regs.rate_step       <= srctl_pkg::STEP_RST;
      regs.decrease_factor <= srctl_pkg::FACTOR_RST;
      regs.error_gain      <= srctl_pkg::GAIN_RST;
      regs.drain_gain      <= srctl_pkg::GAIN_RST;
      regs.payload_bytes   <= srctl_pkg::PAYLOAD_RST;
    end else if (wr) begin
      case (cfg.index)
        srctl_pkg::REG_MODE: begin
          regs.mode <= srctl_pkg::mode_t'(cfg.data[srctl_pkg::MODE_W-1:0]);
        end
        srctl_pkg::REG_STEP: begin
          regs.rate_step <= cfg.data[srctl_pkg::STEP_W-1:0];
        end
        srctl_pkg::REG_FACTOR: begin
          regs.decrease_factor <= cfg.data[srctl_pkg::FACTOR_W-1:0];
        end
        srctl_pkg::REG_EGAIN: begin
          regs.error_gain <= cfg.data[srctl_pkg::GAIN_W-1:0];
        end
        srctl_pkg::REG_DGAIN: begin
          regs.drain_gain <= cfg.data[srctl_pkg::GAIN_W-1:0];
        end
        srctl_pkg::REG_PAYLOAD: begin
          regs.payload_bytes <= cfg.data[srctl_pkg::PAYLOAD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/srctl_ctrl.sv */
// ----------------------------------------------------------------------------
// srctl_ctrl: update sequencer
// Steps each feedback item through the shared multiplier and accumulator
// according to the control mode, then commits into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srctl_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  input  wire srctl_pkg::mode_t         mode,
  input  wire srctl_pkg::srctl_status_t status,
  output srctl_pkg::srctl_cmd_t         cmd
);

  srctl_pkg::state_t state;
  srctl_pkg::state_t state_next;
  logic              out_free;

  assign in_ready = (state == srctl_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srctl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next      = state;
    cmd.load        = 1'b0;
    cmd.mul_sel     = srctl_pkg::MUL_RATE;
    cmd.acc_op      = srctl_pkg::ACC_HOLD;
    cmd.drain_load  = 1'b0;
    cmd.dacc_op     = srctl_pkg::DACC_HOLD;
    cmd.commit      = 1'b0;
    case (state)
      srctl_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = srctl_pkg::S_DECODE;
        end
      end
      srctl_pkg::S_DECODE: begin
        // first product: rate by factor, or error by gain
        cmd.mul_sel = (mode == srctl_pkg::MODE_MULT) ? srctl_pkg::MUL_RATE
                                                     : srctl_pkg::MUL_ERR;
        case (mode)
          srctl_pkg::MODE_ADD: begin
            if (status.err_pos) begin
              cmd.acc_op = srctl_pkg::ACC_ADD_STEP;
            end else if (status.err_neg) begin
              cmd.acc_op = srctl_pkg::ACC_SUB_STEP;
            end
            state_next = srctl_pkg::S_DONE;
          end
          srctl_pkg::MODE_MULT: begin
            if (status.err_pos) begin
              cmd.acc_op = srctl_pkg::ACC_ADD_STEP;
            end
            state_next = status.err_neg ? srctl_pkg::S_SCALE : srctl_pkg::S_DONE;
          end
          default: begin
            state_next = srctl_pkg::S_TERM;
          end
        endcase
      end
      srctl_pkg::S_SCALE: begin
        cmd.acc_op = srctl_pkg::ACC_SCALE;
        state_next = srctl_pkg::S_DONE;
      end
      srctl_pkg::S_TERM: begin
        cmd.acc_op  = srctl_pkg::ACC_ADD_TERM;
        cmd.mul_sel = srctl_pkg::MUL_PAY;
        state_next  = (mode == srctl_pkg::MODE_DRAIN) ? srctl_pkg::S_DRAIN
                                                      : srctl_pkg::S_DONE;
      end
      srctl_pkg::S_DRAIN: begin
        cmd.drain_load = 1'b1;
        state_next     = srctl_pkg::S_MUL_DL;
      end
      srctl_pkg::S_MUL_DL: begin
        cmd.mul_sel = srctl_pkg::MUL_DLOW;
        state_next  = srctl_pkg::S_MUL_DH;
      end
      srctl_pkg::S_MUL_DH: begin
        cmd.dacc_op = srctl_pkg::DACC_LOAD;
        cmd.mul_sel = srctl_pkg::MUL_DHIGH;
        state_next  = srctl_pkg::S_DACC;
      end
      srctl_pkg::S_DACC: begin
        cmd.dacc_op = srctl_pkg::DACC_ADD_HIGH;
        state_next  = srctl_pkg::S_SUB;
      end
      srctl_pkg::S_SUB: begin
        cmd.acc_op = srctl_pkg::ACC_SUB_DRAIN;
        state_next = srctl_pkg::S_DONE;
      end
      srctl_pkg::S_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = srctl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srctl_pkg::S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // An accepted beat always starts decoding
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (state == srctl_pkg::S_IDLE && in_valid) |=> (state == srctl_pkg::S_DECODE))
    else $error("accepted item did not enter decode");

  // A result only appears after the commit state
  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == srctl_pkg::S_DONE))
    else $error("result raised outside commit");

  // The drain path is only walked in drain mode
  a_drain_mode: assert property (@(posedge clk) disable iff (rst)
    (state == srctl_pkg::S_DRAIN) |-> (mode == srctl_pkg::MODE_DRAIN))
    else $error("drain term computed outside drain mode");

endmodule

`default_nettype wire

/* hdl/srctl_dpath.sv */
// ----------------------------------------------------------------------------
// srctl_dpath: rate update datapath
// Kept rate, wide accumulator, one shared registered multiplier, the drain
// difference and its product, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srctl_dpath #(
  parameter int RATE_FRAC_BITS = 16,
  parameter int GAIN_FRAC_BITS = 24,
  parameter int DRAIN_SHIFT    = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire srctl_pkg::srctl_cmd_t                  cmd,
  output srctl_pkg::srctl_status_t                    status,
  input  wire srctl_pkg::srctl_cfg_t                  regs,
  input  wire logic                                   rate_load,
  input  wire logic signed [srctl_pkg::RATE_W-1:0]    rate_init,
  input  wire logic [srctl_pkg::OCC_W-1:0]            occupancy,
  input  wire logic [srctl_pkg::OCC_W-1:0]            target_level,
  input  wire logic [srctl_pkg::GAMMA_W-1:0]          playback_rate,
  output logic signed [srctl_pkg::RATE_W-1:0]         new_rate,
  output logic                                        below_one,
  output logic                                        saturated
);

  // Shift amounts: one of each pair is zero
  localparam int SH_L   = (RATE_FRAC_BITS > GAIN_FRAC_BITS) ?
                          RATE_FRAC_BITS - GAIN_FRAC_BITS : 0;
  localparam int SH_R   = (GAIN_FRAC_BITS >= RATE_FRAC_BITS) ?
                          GAIN_FRAC_BITS - RATE_FRAC_BITS : 0;
  localparam int SH_DL  = (RATE_FRAC_BITS >= DRAIN_SHIFT) ?
                          RATE_FRAC_BITS - DRAIN_SHIFT : 0;
  localparam int SH_DR  = (DRAIN_SHIFT > RATE_FRAC_BITS) ?
                          DRAIN_SHIFT - RATE_FRAC_BITS : 0;
  // Drain, rate minus drain, and its split around the multiplier width
  localparam int DRN_W  = srctl_pkg::GP_W + SH_DL;
  localparam int D_W    = DRN_W + 2;
  localparam int DH_W   = D_W - srctl_pkg::DLOW_W;
  localparam int DACC_W = D_W + srctl_pkg::GAIN_W + 1;
  localparam int TRM_W  = srctl_pkg::MUL_P_W + SH_L;
  localparam int ACC_W  = ((TRM_W > DACC_W) ? TRM_W : DACC_W) + 3;
  localparam logic signed [srctl_pkg::RATE_W-1:0] ONE_RATE =
    srctl_pkg::RATE_W'(1) <<< RATE_FRAC_BITS;

  logic [srctl_pkg::OCC_W-1:0]                occ_q;
  logic [srctl_pkg::OCC_W-1:0]                tgt_q;
  logic [srctl_pkg::GAMMA_W-1:0]              gam_q;
  logic signed [srctl_pkg::RATE_W-1:0]        rate;
  logic signed [ACC_W-1:0]                    acc;
  logic signed [D_W-1:0]                      d_q;
  logic signed [DACC_W-1:0]                   dacc;
  logic signed [srctl_pkg::MUL_P_W-1:0]       prod;
  logic signed [srctl_pkg::ERR_W-1:0]         err;
  logic signed [srctl_pkg::MUL_A_W-1:0]       mul_a;
  logic [srctl_pkg::MUL_B_W-1:0]              mul_b;
  logic signed [ACC_W-1:0]                    prod_x;
  logic signed [ACC_W-1:0]                    term;
  logic signed [ACC_W-1:0]                    scaled;
  logic [DRN_W-1:0]                           drain_v;
  logic signed [D_W-1:0]                      d_next;
  logic signed [DH_W-1:0]                     d_hi;
  logic signed [DACC_W-1:0]                   dacc_sh;
  logic [ACC_W-srctl_pkg::RATE_W:0]           acc_hi;
  logic                                       fits;
  logic signed [srctl_pkg::RATE_W-1:0]        sat_val;

  // Occupancy error and its sign towards the sequencer
  assign err = $signed({1'b0, tgt_q}) - $signed({1'b0, occ_q});
  assign status.err_pos = !err[srctl_pkg::ERR_W-1] && (err != '0);
  assign status.err_neg = err[srctl_pkg::ERR_W-1];

  // Feedback capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      occ_q <= occupancy;
      tgt_q <= target_level;
      gam_q <= playback_rate;
    end
  end

  // Multiplier operand select
  assign d_hi = d_q[D_W-1:srctl_pkg::DLOW_W];
  always_comb begin
    case (cmd.mul_sel)
      srctl_pkg::MUL_ERR: begin
        mul_a = srctl_pkg::MUL_A_W'(err);
        mul_b = srctl_pkg::MUL_B_W'(regs.error_gain);
      end
      srctl_pkg::MUL_PAY: begin
        mul_a = srctl_pkg::MUL_A_W'(regs.payload_bytes);
        mul_b = srctl_pkg::MUL_B_W'(gam_q);
      end
      srctl_pkg::MUL_DLOW: begin
        mul_a = {1'b0, d_q[srctl_pkg::DLOW_W-1:0]};
        mul_b = srctl_pkg::MUL_B_W'(regs.drain_gain);
      end
      srctl_pkg::MUL_DHIGH: begin
        mul_a = srctl_pkg::MUL_A_W'(d_hi);
        mul_b = srctl_pkg::MUL_B_W'(regs.drain_gain);
      end
      default: begin
        mul_a = srctl_pkg::MUL_A_W'(rate);
        mul_b = regs.decrease_factor;
      end
    endcase
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * $signed({1'b0, mul_b});
  end

  // Product views: proportional term, decrease scaling, drain rate
  assign prod_x  = ACC_W'(prod);
  assign term    = (prod_x <<< SH_L) >>> SH_R;
  assign scaled  = prod_x >>> GAIN_FRAC_BITS;
  assign drain_v = (DRN_W'(prod[srctl_pkg::GP_W-1:0]) << SH_DL) >> SH_DR;
  assign d_next  = D_W'(rate) - $signed(D_W'(drain_v));
  assign dacc_sh = dacc >>> GAIN_FRAC_BITS;

  // Rate minus drain
  always_ff @(posedge clk) begin
    if (cmd.drain_load) begin
      d_q <= d_next;
    end
  end

  // Drain gain times difference, low part then high part
  always_ff @(posedge clk) begin
    case (cmd.dacc_op)
      srctl_pkg::DACC_LOAD: begin
        dacc <= DACC_W'(prod);
      end
      srctl_pkg::DACC_ADD_HIGH: begin
        dacc <= dacc + (DACC_W'(prod) <<< srctl_pkg::DLOW_W);
      end
      default: begin
      end
    endcase
  end

  // Update accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= ACC_W'(rate);
    end else begin
      case (cmd.acc_op)
        srctl_pkg::ACC_ADD_STEP:  acc <= acc + $signed(ACC_W'(regs.rate_step));
        srctl_pkg::ACC_SUB_STEP:  acc <= acc - $signed(ACC_W'(regs.rate_step));
        srctl_pkg::ACC_SCALE:     acc <= scaled;
        srctl_pkg::ACC_ADD_TERM:  acc <= acc + term;
        srctl_pkg::ACC_SUB_DRAIN: acc <= acc - ACC_W'(dacc_sh);
        default: begin
        end
      endcase
    end
  end

  // Clip to the signed 32-bit range
  assign acc_hi  = acc[ACC_W-1:srctl_pkg::RATE_W-1];
  assign fits    = (&acc_hi) || !(|acc_hi);
  assign sat_val = fits ? acc[srctl_pkg::RATE_W-1:0] :
                   (acc[ACC_W-1] ? srctl_pkg::RATE_MIN : srctl_pkg::RATE_MAX);

  // Kept rate
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= srctl_pkg::RATE_RST;
    end else if (rate_load) begin
      rate <= rate_init;
    end else if (cmd.commit) begin
      rate <= sat_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      new_rate  <= sat_val;
      below_one <= (sat_val < ONE_RATE);
      saturated <= !fits;
    end
  end

endmodule

`default_nettype wire

/* hdl/stream_rate_controller.sv */
// Sequence: additive updates decode and commit; a multiplicative decrease adds
// a scaling step, proportional updates a term step, and drain mode a drain pass.
// A new item is taken only once the last result is committed; each item passes
// through the single shared multiplier (up to four products for the drain mode).
// Reset: synchronous; registers return to their reset values, rate to 1.0.
// ----------------------------------------------------------------------------
// stream_rate_controller: feedback-driven sending rate update
// Registers, sequencer and datapath for additive, multiplicative and
// proportional rate control with saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_rate_controller #(
  parameter int RATE_FRAC_BITS = 16,
  parameter int GAIN_FRAC_BITS = 24,
  parameter int DRAIN_SHIFT    = 12
) (
  input  wire logic   clk,
  input  wire logic   rst,
  srctl_cfg_if.sink   cfg,
  srctl_feed_if.sink  feed,
  srctl_rate_if.source result
);

  srctl_pkg::srctl_cfg_t                 regs;
  srctl_pkg::srctl_cmd_t                 cmd;
  srctl_pkg::srctl_status_t              status;
  logic                                  rate_load;
  logic signed [srctl_pkg::RATE_W-1:0]   rate_init;

  // Configuration registers
  srctl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .regs      (regs),
    .rate_load (rate_load),
    .rate_init (rate_init)
  );

  // Sequencer
  srctl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (feed.valid),
    .in_ready  (feed.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .mode      (regs.mode),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath
  srctl_dpath #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DRAIN_SHIFT    (DRAIN_SHIFT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .regs          (regs),
    .rate_load     (rate_load),
    .rate_init     (rate_init),
    .occupancy     (feed.occupancy),
    .target_level  (feed.target_level),
    .playback_rate (feed.playback_rate),
    .new_rate      (result.new_rate),
    .below_one     (result.below_one),
    .saturated     (result.saturated)
  );

endmodule

`default_nettype wire
